// ===== rtl/core/integer_pixel_replication_upscaler_defines.svh =====
// Assertion helpers for the upscaler checkers.
`ifndef INTEGER_PIXEL_REPLICATION_UPSCALER_DEFINES_SVH
`define INTEGER_PIXEL_REPLICATION_UPSCALER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define IPRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define IPRU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/ipru_pkg.sv =====
package ipru_pkg;

  // Sizes
  localparam int unsigned MaxWidthDef = 2048;
  localparam int unsigned ScaleW      = 7;
  localparam int unsigned CfgWidthW   = 12;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 12;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [ScaleW-1:0] ScaleLimit = 7'd100;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_SCALE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH = 1'b1;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_PULL = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_EMIT      = 2'd0,
    ST_PUSHED    = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_REJECTED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } mem_op_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    req_e       req_type;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [1:0] pad_bytes;
    logic       row_end;
  } out_item_t;

  // Command handed from the classifier to the line store side
  typedef struct packed {
    mem_op_e    op;
    status_e    status;
    logic [1:0] pad_bytes;
    logic       row_end;
  } cmd_meta_t;

endpackage

// ===== rtl/core/ipru_queue.sv =====
module ipru_queue #(
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] out_data_o
);
  import ipru_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [DataW-1:0] slot_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = (count_q != CntW'(QueueDepth));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = slot_q[rd_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // Advance pointers with wrap, track fill
  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= in_data_i;
    end
  end

endmodule

// ===== rtl/core/ipru_front.sv =====
module ipru_front #(
  parameter int unsigned MaxWidth = ipru_pkg::MaxWidthDef,
  localparam int unsigned AddrW   = (MaxWidth > 1) ? $clog2(MaxWidth) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ipru_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ipru_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ipru_pkg::in_item_t              in_data_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i,
  output ipru_pkg::cmd_meta_t             cmd_meta_o,
  output logic [AddrW-1:0]                cmd_addr_o,
  output ipru_pkg::pixel_t                cmd_pixel_o
);
  import ipru_pkg::*;

  localparam int unsigned CntW = $clog2(MaxWidth + 1);
  localparam int unsigned CmpW = (CntW > CfgWidthW) ? CntW : CfgWidthW;

  logic [ScaleW-1:0]    scale_q;
  logic [CfgWidthW-1:0] width_q;
  logic [ScaleW-1:0]    eff_s;
  logic [CntW-1:0]      eff_w;
  logic [1:0]           w_lo;

  logic [CntW-1:0]   loaded_q, loaded_d;
  logic [AddrW-1:0]  rcol_q, rcol_d;
  logic [ScaleW-1:0] across_q, across_d, down_q, down_d;

  logic [AddrW-1:0]  col;
  logic [CntW-1:0]   col_next;
  logic [ScaleW-1:0] across_inc, down_inc;
  logic              accept;

  // Beats pass straight to the queue; the queue sets the pace
  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;
  assign accept      = in_valid_i && cmd_ready_i;

  // Clamp the registers to their legal ranges
  always_comb begin
    if (scale_q == '0) begin
      eff_s = ScaleW'(1);
    end else if (scale_q > ScaleLimit) begin
      eff_s = ScaleLimit;
    end else begin
      eff_s = scale_q;
    end
    if (width_q == '0) begin
      eff_w = CntW'(1);
    end else if (CmpW'(width_q) > CmpW'(MaxWidth)) begin
      eff_w = CntW'(MaxWidth);
    end else begin
      eff_w = CntW'(width_q);
    end
  end

  assign w_lo       = 2'(eff_w);
  assign col        = (CntW'(rcol_q) < eff_w) ? rcol_q : AddrW'(eff_w - 1'b1);
  assign col_next   = CntW'(col) + 1'b1;
  assign across_inc = across_q + 1'b1;
  assign down_inc   = down_q + 1'b1;

  // Classify the beat and step the replay counters
  always_comb begin
    loaded_d    = loaded_q;
    rcol_d      = rcol_q;
    across_d    = across_q;
    down_d      = down_q;
    cmd_meta_o  = '{op: OP_NONE, status: ST_REJECTED, pad_bytes: 2'd0, row_end: 1'b0};
    cmd_addr_o  = loaded_q[AddrW-1:0];
    cmd_pixel_o = '{red: in_data_i.in_red, green: in_data_i.in_green,
                    blue: in_data_i.in_blue};
    if (in_data_i.req_type == REQ_PUSH) begin
      if (loaded_q < eff_w) begin
        cmd_meta_o.op     = OP_WRITE;
        cmd_meta_o.status = ST_PUSHED;
        loaded_d          = loaded_q + 1'b1;
      end
    end else if (loaded_q < eff_w) begin
      cmd_meta_o.status = ST_NOT_READY;
    end else begin
      cmd_meta_o.op     = OP_READ;
      cmd_meta_o.status = ST_EMIT;
      cmd_addr_o        = col;
      across_d          = across_inc;
      if (across_inc >= eff_s) begin
        across_d = '0;
        rcol_d   = col_next[AddrW-1:0];
        if (col_next >= eff_w) begin
          rcol_d = '0;
          // Row bytes are 3*w*s; pad to 4 is -(3*w*s) mod 4 = w*s mod 4
          cmd_meta_o.pad_bytes = 2'(w_lo * eff_s[1:0]);
          cmd_meta_o.row_end   = 1'b1;
          down_d               = down_inc;
          if (down_inc >= eff_s) begin
            down_d   = '0;
            loaded_d = '0;
          end
        end
      end
    end
  end

  // Counters move only on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      rcol_q   <= '0;
      across_q <= '0;
      down_q   <= '0;
    end else if (accept) begin
      loaded_q <= loaded_d;
      rcol_q   <= rcol_d;
      across_q <= across_d;
      down_q   <= down_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleW'(1);
      width_q <= CfgWidthW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCALE: scale_q <= cfg_data_i[ScaleW-1:0];
        CFG_WIDTH: width_q <= cfg_data_i[CfgWidthW-1:0];
        default:   ;
      endcase
    end
  end

endmodule

// ===== rtl/core/ipru_back.sv =====
module ipru_back #(
  parameter int unsigned MaxWidth = ipru_pkg::MaxWidthDef,
  localparam int unsigned AddrW   = (MaxWidth > 1) ? $clog2(MaxWidth) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  ipru_pkg::cmd_meta_t   cmd_meta_i,
  input  logic [AddrW-1:0]      cmd_addr_i,
  input  ipru_pkg::pixel_t      cmd_pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ipru_pkg::out_item_t   out_data_o
);
  import ipru_pkg::*;

  pixel_t    line_store_q [MaxWidth];
  pixel_t    rdata_q;
  cmd_meta_t meta_q;
  logic      out_valid_q;
  logic      pop;

  // Take a command whenever the output register is free or draining
  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // Line store: at most one access per command, read data registered
  always_ff @(posedge clk_i) begin
    if (pop && (cmd_meta_i.op == OP_WRITE)) begin
      line_store_q[cmd_addr_i] <= cmd_pixel_i;
    end
    if (pop && (cmd_meta_i.op == OP_READ)) begin
      rdata_q <= line_store_q[cmd_addr_i];
    end
  end

  // Hold the result until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      out_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      meta_q <= cmd_meta_i;
    end
  end

  // Drive the result, pixel bytes only for an emitted pixel
  always_comb begin
    out_data_o.status    = meta_q.status;
    out_data_o.pad_bytes = meta_q.pad_bytes;
    out_data_o.row_end   = meta_q.row_end;
    out_data_o.out_blue  = 8'd0;
    out_data_o.out_green = 8'd0;
    out_data_o.out_red   = 8'd0;
    if (meta_q.status == ST_EMIT) begin
      out_data_o.out_blue  = rdata_q.blue;
      out_data_o.out_green = rdata_q.green;
      out_data_o.out_red   = rdata_q.red;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/integer_pixel_replication_upscaler.sv =====
// Channel   Signals                                   Beat
// --------  ----------------------------------------  --------------------------------
// cfg       cfg_we_i, cfg_idx_i, cfg_data_i           register write, no handshake
// in        in_valid_i, in_ready_o, in_data_i         push pixel or pull request
// out       out_valid_o, out_ready_i, out_data_o      one result per request
//
// One request is taken per clock while in_ready_o is high; the line store sees at most one access per clock.
// A taken request passes through the command queue and the output register before its result is shown.
// Reset clears the counters and sets scale and width to 1; the store is not cleared.
// A two-entry command queue and the output register absorb output stalls;
// in_ready_o drops only when that queue is full.
module integer_pixel_replication_upscaler #(
  parameter int unsigned MaxWidth = ipru_pkg::MaxWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ipru_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ipru_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ipru_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ipru_pkg::out_item_t           out_data_o
);
  import ipru_pkg::*;

  localparam int unsigned AddrW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned CmdW  = $bits(cmd_meta_t) + AddrW + $bits(pixel_t);

  logic             f_valid, f_ready;
  cmd_meta_t        f_meta;
  logic [AddrW-1:0] f_addr;
  pixel_t           f_pixel;

  logic             b_valid, b_ready;
  cmd_meta_t        b_meta;
  logic [AddrW-1:0] b_addr;
  pixel_t           b_pixel;

  logic [CmdW-1:0]  q_in, q_out;

  // Classify requests and keep the row counters
  ipru_front #(
    .MaxWidth (MaxWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_meta_o  (f_meta),
    .cmd_addr_o  (f_addr),
    .cmd_pixel_o (f_pixel)
  );

  assign q_in = {f_meta, f_addr, f_pixel};

  // Decouple classification from store access
  ipru_queue #(
    .DataW (CmdW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (q_in),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (q_out)
  );

  assign {b_meta, b_addr, b_pixel} = q_out;

  // Access the line store and register the result
  ipru_back #(
    .MaxWidth (MaxWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_meta_i  (b_meta),
    .cmd_addr_i  (b_addr),
    .cmd_pixel_i (b_pixel),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/ipru_checker.sv =====
`include "integer_pixel_replication_upscaler_defines.svh"

module ipru_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ipru_pkg::out_item_t out_data_o
);
  import ipru_pkg::*;

  // Leaving reset: ready to take a beat, nothing to show
  `IPRU_ASSERT_ALWAYS(a_reset_quiet, $rose(rst_ni) |-> (in_ready_o && !out_valid_o), "not idle after reset")

  // Hold a stalled result
  `IPRU_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)), "stalled result changed")

  // Only an emitted pixel carries bytes or row marks
  `IPRU_ASSERT(a_non_emit_zero, (out_valid_o && (out_data_o.status != ST_EMIT)) |-> ((out_data_o.out_red == 8'd0) && (out_data_o.out_green == 8'd0) && (out_data_o.out_blue == 8'd0) && (out_data_o.pad_bytes == 2'd0) && !out_data_o.row_end), "status without pixel has payload")

  // Padding appears only at a row end
  `IPRU_ASSERT(a_pad_at_row_end, (out_valid_o && (out_data_o.pad_bytes != 2'd0)) |-> (out_data_o.row_end && (out_data_o.status == ST_EMIT)), "padding off row end")

endmodule

bind integer_pixel_replication_upscaler ipru_checker u_checker (.*);
